// ===== hw/rtl/ffrn_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ffrn_pkg
// Shared types and constants of the frame flip / rotate / negate engine.
// ----------------------------------------------------------------------------
package ffrn_pkg;

    localparam int MAX_WIDTH_DEF  = 512;
    localparam int MAX_HEIGHT_DEF = 512;

    localparam int DIM_W   = 10;
    localparam int DIM_MAX = 1023;
    localparam int PIX_W   = 8;
    localparam int MODE_W  = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GREY_MAX     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE         = 2'd3;

    localparam logic [MODE_W-1:0] MODE_COPY  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_NEG   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_HFLIP = 3'd2;
    localparam logic [MODE_W-1:0] MODE_VFLIP = 3'd3;
    localparam logic [MODE_W-1:0] MODE_ROT90 = 3'd4;

    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_FETCH = 1'b1;

    typedef struct packed {
        logic capture;
        logic load;
        logic calc;
        logic mul;
        logic read;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic frame_full;
        logic out_free;
    } t_sts;

endpackage
`default_nettype wire

// ===== hw/rtl/ffrn_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ffrn_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module ffrn_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_addr,
    input  wire logic [WIDTH-1:0] i_wdata,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_addr];
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/ffrn_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ffrn_ctrl
// Sequencer: steps each transaction through load or fetch phases.
// ----------------------------------------------------------------------------
module ffrn_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    input  wire logic          i_req_type,
    output logic               o_in_stall,
    input  wire ffrn_pkg::t_sts i_sts,
    output ffrn_pkg::t_cmd     o_cmd
);
    import ffrn_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_LOAD = 3'd1;
    localparam logic [2:0] S_CALC = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_READ = 3'd4;
    localparam logic [2:0] S_EMIT = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       accept;

    assign o_in_stall = (r_state != S_IDLE);
    assign accept     = i_in_valid && !o_in_stall;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.capture = 1'b1;
                    if (i_req_type == REQ_LOAD) begin
                        n_state = S_LOAD;
                    end else if (i_sts.frame_full) begin
                        n_state = S_CALC;
                    end else begin
                        n_state = S_EMIT;
                    end
                end
            end
            S_LOAD: begin
                o_cmd.load = 1'b1;
                n_state    = S_IDLE;
            end
            S_CALC: begin
                o_cmd.calc = 1'b1;
                n_state    = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_READ;
            end
            S_READ: begin
                o_cmd.read = 1'b1;
                n_state    = S_EMIT;
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/ffrn_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ffrn_dp
// Datapath: config registers, frame store, address generation, output stage.
// ----------------------------------------------------------------------------
module ffrn_dp #(
    parameter int MAX_WIDTH  = ffrn_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = ffrn_pkg::MAX_HEIGHT_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [ffrn_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [ffrn_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic [ffrn_pkg::PIX_W-1:0]      i_pixel_in,
    input  wire ffrn_pkg::t_cmd                  i_cmd,
    output ffrn_pkg::t_sts                       o_sts,
    input  wire logic                            i_out_stall,
    output logic                                 o_out_valid,
    output logic      [ffrn_pkg::PIX_W-1:0]      o_pixel_out,
    output logic                                 o_row_end,
    output logic                                 o_last,
    output logic                                 o_status
);
    import ffrn_pkg::*;

    localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW   = $clog2(DEPTH + 1) + 1;
    localparam int WMAX_I = (MAX_WIDTH > DIM_MAX) ? DIM_MAX : MAX_WIDTH;
    localparam int HMAX_I = (MAX_HEIGHT > DIM_MAX) ? DIM_MAX : MAX_HEIGHT;
    localparam logic [DIM_W-1:0] WMAX = WMAX_I[DIM_W-1:0];
    localparam logic [DIM_W-1:0] HMAX = HMAX_I[DIM_W-1:0];
    localparam logic [DIM_W-1:0] ONE  = DIM_W'(1);

    // configuration
    logic [DIM_W-1:0]  r_width_cfg;
    logic [DIM_W-1:0]  r_height_cfg;
    logic [PIX_W-1:0]  r_grey_max;
    logic [MODE_W-1:0] r_mode;

    logic [DIM_W-1:0]  w;
    logic [DIM_W-1:0]  h;
    logic [CNTW-1:0]   r_total;

    // frame state
    logic [CNTW-1:0]   r_count;
    logic              r_full;
    logic [DIM_W-1:0]  r_out_row;
    logic [DIM_W-1:0]  r_out_col;

    // fetch pipeline
    logic [PIX_W-1:0]  r_pix;
    logic [DIM_W-1:0]  r_sr;
    logic [DIM_W-1:0]  r_sc;
    logic [DIM_W-1:0]  r_wm;
    logic [DIM_W-1:0]  r_r;
    logic [DIM_W-1:0]  r_c;
    logic              r_re;
    logic              r_lst;
    logic [AW-1:0]     r_addr;

    // output stage
    logic              r_out_valid;
    logic [PIX_W-1:0]  r_pixel_out;
    logic              r_row_end;
    logic              r_last;
    logic              r_status;

    logic [DIM_W-1:0]  ow;
    logic [DIM_W-1:0]  oh;
    logic [DIM_W-1:0]  c;
    logic [DIM_W-1:0]  r;
    logic [DIM_W-1:0]  sr;
    logic [DIM_W-1:0]  sc;
    logic              re;
    logic [2*DIM_W-1:0] area;
    logic              wr;
    logic [CNTW-1:0]   cnt_inc;
    logic [AW-1:0]     ram_addr;
    logic [PIX_W-1:0]  ram_rdata;
    logic [PIX_W-1:0]  pix_res;
    logic              out_free;

    always_comb begin
        if (r_width_cfg == '0) begin
            w = ONE;
        end else if (r_width_cfg > WMAX) begin
            w = WMAX;
        end else begin
            w = r_width_cfg;
        end
        if (r_height_cfg == '0) begin
            h = ONE;
        end else if (r_height_cfg > HMAX) begin
            h = HMAX;
        end else begin
            h = r_height_cfg;
        end
    end

    assign area = w * h;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width_cfg  <= ONE;
            r_height_cfg <= ONE;
            r_grey_max   <= '1;
            r_mode       <= MODE_COPY;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_FRAME_WIDTH:  r_width_cfg  <= i_cfg_data[DIM_W-1:0];
                CFG_FRAME_HEIGHT: r_height_cfg <= i_cfg_data[DIM_W-1:0];
                CFG_GREY_MAX:     r_grey_max   <= i_cfg_data[PIX_W-1:0];
                CFG_MODE:         r_mode       <= i_cfg_data[MODE_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_total <= CNTW'(area);
    end

    // output position, clamped to the current output frame
    always_comb begin
        ow = (r_mode == MODE_ROT90) ? h : w;
        oh = (r_mode == MODE_ROT90) ? w : h;
        c  = (r_out_col < ow - ONE) ? r_out_col : ow - ONE;
        r  = (r_out_row < oh - ONE) ? r_out_row : oh - ONE;
        re = (c == ow - ONE);
        unique case (r_mode)
            MODE_HFLIP: begin
                sr = r;
                sc = w - ONE - c;
            end
            MODE_VFLIP: begin
                sr = h - ONE - r;
                sc = c;
            end
            MODE_ROT90: begin
                sr = h - ONE - c;
                sc = r;
            end
            default: begin
                sr = r;
                sc = c;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_pix <= i_pixel_in;
        end
        if (i_cmd.calc) begin
            r_sr  <= sr;
            r_sc  <= sc;
            r_wm  <= w;
            r_r   <= r;
            r_c   <= c;
            r_re  <= re;
            r_lst <= re && (r == oh - ONE);
        end
        if (i_cmd.mul) begin
            r_addr <= AW'(r_sr * r_wm + {{DIM_W{1'b0}}, r_sc});
        end
    end

    assign wr       = i_cmd.load && !r_full && (r_count < r_total);
    assign cnt_inc  = r_count + CNTW'(1);
    assign ram_addr = i_cmd.load ? r_count[AW-1:0] : r_addr;

    ffrn_ram #(
        .WIDTH (PIX_W),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (wr),
        .i_re    (i_cmd.read),
        .i_addr  (ram_addr),
        .i_wdata (r_pix),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        if (r_mode == MODE_NEG) begin
            pix_res = (ram_rdata > r_grey_max) ? '0 : r_grey_max - ram_rdata;
        end else begin
            pix_res = ram_rdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_full    <= 1'b0;
            r_out_row <= '0;
            r_out_col <= '0;
        end else if (i_cmd.load) begin
            if (!r_full) begin
                if (wr) begin
                    r_count <= cnt_inc;
                end
                if ((wr ? cnt_inc : r_count) >= r_total) begin
                    r_full <= 1'b1;
                end
            end
        end else if (i_cmd.emit && r_full) begin
            if (r_lst) begin
                r_count   <= '0;
                r_full    <= 1'b0;
                r_out_row <= '0;
                r_out_col <= '0;
            end else if (r_re) begin
                r_out_col <= '0;
                r_out_row <= r_r + ONE;
            end else begin
                r_out_col <= r_c + ONE;
                r_out_row <= r_r;
            end
        end
    end

    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            if (r_full) begin
                r_pixel_out <= pix_res;
                r_row_end   <= r_re;
                r_last      <= r_lst;
                r_status    <= 1'b0;
            end else begin
                r_pixel_out <= '0;
                r_row_end   <= 1'b0;
                r_last      <= 1'b0;
                r_status    <= 1'b1;
            end
        end
    end

    assign o_sts.frame_full = r_full;
    assign o_sts.out_free   = out_free;
    assign o_out_valid      = r_out_valid;
    assign o_pixel_out      = r_pixel_out;
    assign o_row_end        = r_row_end;
    assign o_last           = r_last;
    assign o_status         = r_status;

endmodule
`default_nettype wire

// ===== hw/rtl/frame_flip_rotate_negate_engine.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// frame_flip_rotate_negate_engine
// Greyscale frame store with copy, negative, mirror and 90-degree rotation.
// ----------------------------------------------------------------------------
// One transaction is handled at a time. A load goes through its load step;
// a fetch of a complete frame steps through clamp and source position,
// address multiply, frame store read and output stage, and a fetch before
// the frame is complete goes straight to the output stage. The address
// multiply and the registered read of the single-port frame store lengthen
// the fetch. The output register frees the input side once a result is
// parked there. The frame store is not cleared at reset; the user must see
// that only written pixels are read, and the block itself does not enforce it.
module frame_flip_rotate_negate_engine #(
    parameter int MAX_WIDTH  = ffrn_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = ffrn_pkg::MAX_HEIGHT_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [ffrn_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [ffrn_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_stall,
    input  wire logic                            i_req_type,
    input  wire logic [ffrn_pkg::PIX_W-1:0]      i_pixel_in,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_stall,
    output logic      [ffrn_pkg::PIX_W-1:0]      o_pixel_out,
    output logic                                 o_row_end,
    output logic                                 o_last,
    output logic                                 o_status
);
    import ffrn_pkg::*;

    t_cmd cmd;
    t_sts sts;

    ffrn_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_req_type (i_req_type),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    ffrn_dp #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_pixel_in  (i_pixel_in),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_pixel_out (o_pixel_out),
        .o_row_end   (o_row_end),
        .o_last      (o_last),
        .o_status    (o_status)
    );

endmodule
`default_nettype wire

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the frame flip / rotate / negate engine.
// ----------------------------------------------------------------------------
// Frames are loaded and emitted through the valid/stall channels. A shadow
// copy of the engine, kept in this file, predicts every output transaction
// when its fetch is accepted. Register writes happen only while the engine
// is idle. Directed frames come first. Random frames follow, with mixed
// sizes, modes, noise requests and partial loads or emissions. Two frames
// are 512 pixels long and are cut short by shrinking the frame during
// emission. Both sides insert random gaps.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import ffrn_pkg::*;

    localparam int MAX_W         = MAX_WIDTH_DEF;
    localparam int MAX_H         = MAX_HEIGHT_DEF;
    localparam int SETTLE_CYCLES = 12;
    localparam int QUIET_LIMIT   = 2000;
    localparam int RANDOM_ITEMS  = 1600;

    typedef struct packed {
        logic             req;
        logic [PIX_W-1:0] pix;
    } t_request;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             row_end;
        logic             frame_end;
        logic             status;
    } t_pix_result;

    typedef struct {
        logic [DIM_W-1:0]  width_reg;
        logic [DIM_W-1:0]  height_reg;
        logic [PIX_W-1:0]  grey_reg;
        logic [MODE_W-1:0] mode_reg;
        int unsigned       loaded;
        int unsigned       row;
        int unsigned       col;
        bit                full;
    } t_engine;

    typedef enum {SEG_FULL, SEG_STOP_LOAD, SEG_STOP_EMIT, SEG_BIG} t_seg_kind;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic                  req_type = REQ_LOAD;
    logic [PIX_W-1:0]      pixel_in = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [PIX_W-1:0]      pixel_out;
    logic                  row_end;
    logic                  out_last;
    logic                  status;

    logic [PIX_W-1:0] frame_mem [0:MAX_W*MAX_H-1];
    int unsigned      filled_top = 0;
    t_engine          eng = '{DIM_W'(1), DIM_W'(1), 8'd255, MODE_COPY, 0, 0, 0, 1'b0};

    t_request    pending_reqs [$];
    t_pix_result expected_out [$];

    int unsigned reqs_pushed = 0;
    int unsigned reqs_accepted = 0;
    int unsigned loads_in = 0;
    int unsigned fetches_in = 0;
    int unsigned results_checked = 0;
    int unsigned frames_done = 0;
    int unsigned cfg_writes = 0;
    int unsigned stim_count = 0;
    int unsigned mismatches = 0;
    bit          steady = 1'b0;

    frame_flip_rotate_negate_engine uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_req_type  (req_type),
        .i_pixel_in  (pixel_in),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_pixel_out (pixel_out),
        .o_row_end   (row_end),
        .o_last      (out_last),
        .o_status    (status)
    );

    always #5ns clk = ~clk;

    function automatic int unsigned clamp_dim(input logic [DIM_W-1:0] v, input int maxv);
        if (v == 0) return 1;
        if (v > maxv) return maxv;
        return v;
    endfunction

    function automatic int unsigned frame_total(input t_engine s);
        return clamp_dim(s.width_reg, MAX_W) * clamp_dim(s.height_reg, MAX_H);
    endfunction

    function automatic void set_reg(inout t_engine s, input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_FRAME_WIDTH:  s.width_reg = data[DIM_W-1:0];
            CFG_FRAME_HEIGHT: s.height_reg = data[DIM_W-1:0];
            CFG_GREY_MAX:     s.grey_reg = data[PIX_W-1:0];
            CFG_MODE:         s.mode_reg = data[MODE_W-1:0];
            default: ;
        endcase
    endfunction

    // Advances the shadow engine by one transaction; returns 1 when it yields
    // an output pixel. The frame store is written only when commit is set.
    function automatic bit engine_step(inout t_engine s, input logic req,
                                       input logic [PIX_W-1:0] pix, input bit commit,
                                       output t_pix_result res);
        int unsigned w, h, ow, oh, c, r, sr, sc;
        logic [PIX_W-1:0] v;
        bit rot;
        w = clamp_dim(s.width_reg, MAX_W);
        h = clamp_dim(s.height_reg, MAX_H);
        res = '0;
        if (req == REQ_LOAD) begin
            if (!s.full) begin
                if (s.loaded < w * h) begin
                    if (commit) begin
                        frame_mem[s.loaded] = pix;
                        if (s.loaded + 1 > filled_top) filled_top = s.loaded + 1;
                    end
                    s.loaded++;
                end
                if (s.loaded >= w * h) s.full = 1'b1;
            end
            return 1'b0;
        end
        if (!s.full) begin
            res.status = 1'b1;
            return 1'b1;
        end
        rot = (s.mode_reg == MODE_ROT90);
        ow = rot ? h : w;
        oh = rot ? w : h;
        c = (s.col < ow - 1) ? s.col : ow - 1;
        r = (s.row < oh - 1) ? s.row : oh - 1;
        res.row_end = (c == ow - 1);
        res.frame_end = res.row_end && (r == oh - 1);
        case (s.mode_reg)
            MODE_HFLIP: begin sr = r;         sc = w - 1 - c; end
            MODE_VFLIP: begin sr = h - 1 - r; sc = c;         end
            MODE_ROT90: begin sr = h - 1 - c; sc = r;         end
            default:    begin sr = r;         sc = c;         end
        endcase
        v = frame_mem[sr * w + sc];
        if (s.mode_reg == MODE_NEG) v = (v > s.grey_reg) ? 8'd0 : s.grey_reg - v;
        res.pixel = v;
        if (res.frame_end) begin
            s.loaded = 0;
            s.row = 0;
            s.col = 0;
            s.full = 1'b0;
        end else if (res.row_end) begin
            s.col = 0;
            s.row = r + 1;
        end else begin
            s.col = c + 1;
            s.row = r;
        end
        return 1'b1;
    endfunction

    function automatic logic [PIX_W-1:0] rand_pixel(input logic [PIX_W-1:0] g);
        int unsigned p;
        p = $urandom_range(0, 99);
        if (p < 8) return 8'h00;
        if (p < 16) return 8'hFF;
        if (p < 22) return g;
        if (p < 28) return g + 8'd1;
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_value(input logic [CFG_IDX_W-1:0] idx);
        int unsigned p;
        logic [CFG_DATA_W-1:0] v;
        p = $urandom_range(0, 99);
        v = CFG_DATA_W'($urandom);
        case (idx)
            CFG_GREY_MAX:
                v[PIX_W-1:0] = (p < 10) ? 8'd1 : (p < 20) ? 8'd255 : 8'($urandom_range(2, 254));
            CFG_MODE:
                v[MODE_W-1:0] = (p < 85) ? 3'($urandom_range(0, 4)) : 3'($urandom_range(5, 7));
            default:
                v = (p < 5) ? '0 : (p < 93) ? CFG_DATA_W'($urandom_range(1, 6))
                                            : CFG_DATA_W'($urandom_range(7, 12));
        endcase
        return v;
    endfunction

    task automatic push_req(input logic req, input logic [PIX_W-1:0] pix);
        pending_reqs.push_back({req, pix});
        reqs_pushed++;
    endtask

    task automatic wait_quiet();
        while (reqs_accepted != reqs_pushed || expected_out.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        set_reg(eng, idx, data);
        cfg_writes++;
    endtask

    // Skips a write that would make a full frame read pixels never loaded.
    task automatic try_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        t_engine t;
        t = eng;
        set_reg(t, idx, data);
        if (t.full && frame_total(t) > filled_top) return;
        write_reg(idx, data);
    endtask

    task automatic plan_segment(input t_seg_kind kind);
        t_engine plan;
        t_pix_result r;
        t_request q;
        int unsigned fetched, stop_after;
        bit got;
        plan = eng;
        fetched = 0;
        stop_after = $urandom_range(5, 30);
        for (int n = 0; n < 4000; n++) begin
            if (!plan.full) begin
                if (kind == SEG_STOP_LOAD && $urandom_range(0, 24) == 0) break;
                q.req = ($urandom_range(0, 99) < 3) ? REQ_FETCH : REQ_LOAD;
            end else begin
                if (kind == SEG_STOP_EMIT && $urandom_range(0, 15) == 0) break;
                if (kind == SEG_BIG && fetched == stop_after) break;
                q.req = ($urandom_range(0, 99) < 4) ? REQ_LOAD : REQ_FETCH;
            end
            q.pix = rand_pixel(plan.grey_reg);
            if (q.req == REQ_FETCH || !plan.full) stim_count++;
            got = engine_step(plan, q.req, q.pix, 1'b0, r);
            push_req(q.req, q.pix);
            if (got && !r.status) fetched++;
            if (got && r.frame_end) break;
        end
    endtask

    // Request driver
    always @(posedge clk) begin : driver
        t_pix_result res;
        t_request cur;
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !in_stall) begin
                reqs_accepted++;
                if (req_type == REQ_LOAD) loads_in++;
                else fetches_in++;
                if (engine_step(eng, req_type, pixel_in, 1'b1, res)) expected_out.push_back(res);
            end
            if (!in_valid || !in_stall) begin
                if (pending_reqs.size() > 0 && (steady || $urandom_range(0, 99) >= 18)) begin
                    cur = pending_reqs.pop_front();
                    in_valid <= 1'b1;
                    req_type <= cur.req;
                    pixel_in <= cur.pix;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor and receiver stall
    always @(posedge clk) begin : monitor
        t_pix_result seen, want;
        int unsigned cyc, hold_left;
        if (!rst_n) begin
            out_stall <= 1'b0;
            cyc = 0;
            hold_left = 0;
        end else begin
            if (out_valid && !out_stall) begin
                seen = {pixel_out, row_end, out_last, status};
                results_checked++;
                if (expected_out.size() == 0) begin
                    mismatches++;
                    $display({"%0t: mismatch expected no transaction, ",
                              "actual pixel %0d row_end %0b last %0b status %0b"},
                             $time, seen.pixel, seen.row_end, seen.frame_end, seen.status);
                end else begin
                    want = expected_out.pop_front();
                    if (seen !== want) begin
                        mismatches++;
                        $display({"%0t: mismatch expected pixel %0d row_end %0b last %0b ",
                                  "status %0b, actual pixel %0d row_end %0b last %0b status %0b"},
                                 $time, want.pixel, want.row_end, want.frame_end, want.status,
                                 seen.pixel, seen.row_end, seen.frame_end, seen.status);
                    end
                    if (want.frame_end) frames_done++;
                end
            end
            cyc++;
            if (cyc % 3000 == 1500) hold_left = 90;
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else begin
                out_stall <= !steady && ($urandom_range(0, 99) < 18);
            end
        end
    end

    // Watchdog on cycles without any transaction
    always @(posedge clk) begin : watchdog
        int unsigned quiet;
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we || !rst_n) begin
            quiet = 0;
        end else begin
            quiet++;
            if (quiet >= QUIET_LIMIT) begin
                $display("%0t: no progress for %0d cycles", $time, QUIET_LIMIT);
                $display("testbench NOT OK");
                $finish;
            end
        end
    end

    initial begin : stimulus
        int unsigned seg, big_done, p;
        bit shrink_next;
        logic [CFG_IDX_W-1:0] idx;
        seg = 0;
        big_done = 0;
        shrink_next = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // 1x1 frame at reset values: early fetch, load, ignored load, fetch
        push_req(REQ_FETCH, 8'h00);
        push_req(REQ_LOAD, 8'hA5);
        push_req(REQ_LOAD, 8'h5A);
        push_req(REQ_FETCH, 8'hFF);
        wait_quiet();

        // 2x2 negative with pixels around grey_max
        write_reg(CFG_FRAME_WIDTH, 10'd2);
        write_reg(CFG_FRAME_HEIGHT, 10'd2);
        write_reg(CFG_GREY_MAX, 10'd200);
        write_reg(CFG_MODE, CFG_DATA_W'(MODE_NEG));
        push_req(REQ_LOAD, 8'h00);
        push_req(REQ_FETCH, 8'h00);
        push_req(REQ_LOAD, 8'd200);
        push_req(REQ_LOAD, 8'd201);
        push_req(REQ_LOAD, 8'hFF);
        push_req(REQ_LOAD, 8'h11);
        repeat (4) push_req(REQ_FETCH, 8'h00);

        while (stim_count < RANDOM_ITEMS) begin
            wait_quiet();
            steady = (seg >= 20 && seg < 35);
            if (big_done < 2 && seg >= 3 + 11 * big_done && !eng.full) begin
                write_reg(CFG_FRAME_WIDTH, big_done ? 10'd0 : 10'h3FF);
                write_reg(CFG_FRAME_HEIGHT, big_done ? 10'h3FF : 10'd0);
                write_reg(CFG_MODE, CFG_DATA_W'($urandom_range(0, 4)));
                big_done++;
                shrink_next = 1'b1;
                plan_segment(SEG_BIG);
            end else begin
                if (shrink_next) begin
                    // frame shrinks under an emission in progress
                    write_reg(CFG_FRAME_WIDTH, CFG_DATA_W'($urandom_range(1, 3)));
                    write_reg(CFG_FRAME_HEIGHT, CFG_DATA_W'($urandom_range(1, 3)));
                    shrink_next = 1'b0;
                end else if ($urandom_range(0, 1)) begin
                    repeat ($urandom_range(1, 4)) begin
                        idx = CFG_IDX_W'($urandom_range(0, 3));
                        try_write(idx, pick_value(idx));
                    end
                end
                p = $urandom_range(0, 99);
                plan_segment(p < 10 ? SEG_STOP_LOAD : p < 25 ? SEG_STOP_EMIT : SEG_FULL);
            end
            seg++;
        end
        steady = 1'b0;
        wait_quiet();

        $display("%0d transactions in (%0d loads, %0d fetches) over %0d segments",
                 reqs_accepted, loads_in, fetches_in, seg);
        $display("%0d results checked, %0d frames emitted, %0d register writes",
                 results_checked, frames_done, cfg_writes);
        if (mismatches == 0 && expected_out.size() == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule
